>>> hw/rtl/vector_distance_engine_macros.svh
// ----------------------------------------------------------------------------
// vector_distance_engine_macros
// assertion helpers for the vector distance engine
// ----------------------------------------------------------------------------
`ifndef VECTOR_DISTANCE_ENGINE_MACROS_SVH
`define VECTOR_DISTANCE_ENGINE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define VDE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication outside reset
`define VDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/vde_pkg.sv
// ----------------------------------------------------------------------------
// vde_pkg
// shared types and constants of the vector distance engine
// ----------------------------------------------------------------------------
`default_nettype none
package vde_pkg;

  localparam int unsigned ElemW = 16;
  localparam int unsigned AccW  = 48;
  localparam int unsigned DistW = 44;
  localparam int unsigned ProdW = 34;

  typedef enum logic [1:0] {
    METRIC_L2  = 2'd0,
    METRIC_COS = 2'd1,
    METRIC_IP  = 2'd2,
    METRIC_IP3 = 2'd3
  } metric_e;

  typedef struct packed {
    logic signed [ElemW-1:0] elem_a;
    logic signed [ElemW-1:0] elem_b;
    logic                    last;
  } in_word_t;

  typedef struct packed {
    logic signed [DistW-1:0] distance;
    logic                    saturated;
  } out_word_t;

  // terms handed from front to back
  typedef struct packed {
    logic signed [ProdW-1:0] prim;
    logic signed [ProdW-1:0] na;
    logic signed [ProdW-1:0] nb;
    logic                    use_norm;
    logic                    last;
    metric_e                 metric;
  } term_t;

endpackage
`default_nettype wire

>>> hw/rtl/vde_front.sv
// ----------------------------------------------------------------------------
// vde_front
// accepts element pairs, forms products and marks the vector end
// ----------------------------------------------------------------------------
`default_nettype none
module vde_front #(
  parameter int unsigned MaxDim = 1024
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire  [1:0]            metric_i,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  vde_pkg::in_word_t     in_data_i,
  output logic                  term_valid_o,
  input  wire                   term_ready_i,
  output vde_pkg::term_t        term_o
);
  import vde_pkg::*;

  localparam int unsigned CntW = (MaxDim > 1) ? $clog2(MaxDim) : 1;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            vld_q;
  term_t           term_q;
  logic            take, vlast;
  logic signed [ElemW:0] diff;
  metric_e         m;

  assign m          = metric_e'(metric_i);
  assign in_ready_o = !vld_q || term_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign vlast      = in_data_i.last || ({1'b0, cnt_q} >= (CntW+1)'(MaxDim - 1));
  assign diff       = (ElemW+1)'(in_data_i.elem_a) - (ElemW+1)'(in_data_i.elem_b);

  // element counter within a vector
  always_comb begin
    cnt_d = cnt_q;
    if (take) cnt_d = vlast ? '0 : cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (take) vld_q <= 1'b1;
      else if (term_ready_i) vld_q <= 1'b0;
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (take) begin
      term_q.prim <= (m == METRIC_L2) ? ProdW'(diff * diff)
                                      : ProdW'(in_data_i.elem_a * in_data_i.elem_b);
      term_q.na       <= ProdW'(in_data_i.elem_a * in_data_i.elem_a);
      term_q.nb       <= ProdW'(in_data_i.elem_b * in_data_i.elem_b);
      term_q.use_norm <= (m == METRIC_COS);
      term_q.last     <= vlast;
      term_q.metric   <= m;
    end
  end

  assign term_valid_o = vld_q;
  assign term_o       = term_q;
endmodule
`default_nettype wire

>>> hw/rtl/vde_queue.sv
// ----------------------------------------------------------------------------
// vde_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
module vde_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             wr_valid_i,
  output logic            wr_ready_o,
  input  vde_pkg::term_t  wr_data_i,
  output logic            rd_valid_o,
  input  wire             rd_ready_i,
  output vde_pkg::term_t  rd_data_o
);
  import vde_pkg::*;

  term_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/vde_back.sv
// ----------------------------------------------------------------------------
// vde_back
// accumulates terms and finishes each vector, with root and divide for cosine
// ----------------------------------------------------------------------------
`default_nettype none
module vde_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 term_valid_i,
  output logic                term_ready_o,
  input  vde_pkg::term_t      term_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output vde_pkg::out_word_t  out_data_o
);
  import vde_pkg::*;

  typedef enum logic [4:0] {
    ST_ACC  = 5'b00001,
    ST_SQA  = 5'b00010,
    ST_SQB  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DIV  = 5'b10000
  } state_e;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [AccW+1:0] OutMax = (AccW+2)'((64'd1 << (DistW-1)) - 1);
  localparam logic signed [AccW+1:0] OutMin = -(AccW+2)'(64'd1 << (DistW-1));
  localparam logic [AccW-1:0] One = AccW'(64'd1 << 24);

  state_e state_q;
  logic signed [AccW-1:0] p_q, a_q, b_q;
  logic sat_q;
  logic [AccW-1:0] x_q, res_q, bit_q, ra_q, rb_q, den_q, rem_q, mag_q;
  logic [23:0] q_q;
  logic [4:0]  i_q;
  logic        neg_q;
  logic        ovld_q;
  out_word_t   odat_q;

  // saturating add
  function automatic logic [AccW:0] sadd(logic signed [AccW-1:0] acc,
                                         logic signed [ProdW-1:0] t);
    logic signed [AccW:0] r;
    r = (AccW+1)'(acc) + (AccW+1)'(t);
    if (r > (AccW+1)'(AccMax)) return {1'b1, AccMax};
    if (r < (AccW+1)'(AccMin)) return {1'b1, AccMin};
    return {1'b0, r[AccW-1:0]};
  endfunction

  logic [AccW:0] sp, sa, sb;
  logic take, can_emit;
  logic div_busy, emit_dir, emit_cos;
  logic [AccW-1:0] trial;
  logic signed [AccW+1:0] v;
  logic [AccW:0] rsh;

  assign sp = sadd(p_q, term_i.prim);
  assign sa = sadd(a_q, term_i.na);
  assign sb = sadd(b_q, term_i.nb);
  assign can_emit = !ovld_q || out_ready_i;
  assign term_ready_o = (state_q == ST_ACC) && (!term_i.last || term_i.metric == METRIC_COS
                        || can_emit);
  assign take = term_valid_i && term_ready_o;
  assign trial = res_q + bit_q;
  assign rsh = {rem_q, 1'b0};

  // result launch points
  assign div_busy = (i_q < 5'd24) && (den_q != '0) && (mag_q < den_q);
  assign emit_dir = (state_q == ST_ACC) && take && term_i.last
                    && (term_i.metric != METRIC_COS);
  assign emit_cos = (state_q == ST_DIV) && !div_busy && can_emit;

  // final value for direct metrics
  always_comb begin
    if (term_i.metric == METRIC_L2) v = (AccW+2)'($signed(sp[AccW-1:0]));
    else v = -(AccW+2)'($signed(sp[AccW-1:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      p_q <= '0; a_q <= '0; b_q <= '0; sat_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      if (emit_dir || emit_cos) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
      unique case (state_q)
        ST_ACC: if (take) begin
          if (!term_i.last) begin
            p_q <= sp[AccW-1:0];
            sat_q <= sat_q | sp[AccW] | (term_i.use_norm & (sa[AccW] | sb[AccW]));
            if (term_i.use_norm) begin
              a_q <= sa[AccW-1:0]; b_q <= sb[AccW-1:0];
            end
          end else if (term_i.metric == METRIC_COS) begin
            p_q <= sp[AccW-1:0];
            sat_q <= sat_q | sp[AccW] | sa[AccW] | sb[AccW];
            x_q <= sa[AccW-1] ? '0 : sa[AccW-1:0];
            b_q <= sb[AccW-1:0];
            res_q <= '0; bit_q <= AccW'(64'd1 << 46);
            state_q <= ST_SQA;
          end else begin
            // emit direct result
            odat_q.distance <= (v > OutMax) ? DistW'(OutMax) :
                               (v < OutMin) ? DistW'(OutMin) : DistW'(v);
            odat_q.saturated <= sat_q | sp[AccW] | (v > OutMax) | (v < OutMin)
                                | (term_i.use_norm & (sa[AccW] | sb[AccW]));
            p_q <= '0; a_q <= '0; b_q <= '0; sat_q <= 1'b0;
          end
        end
        // root of norm a, then of norm b, one digit per cycle
        ST_SQA, ST_SQB: begin
          if (!bit_q[0]) begin
            if (x_q >= trial) begin
              x_q <= x_q - trial; res_q <= (res_q >> 1) + bit_q;
            end else res_q <= res_q >> 1;
            bit_q <= bit_q >> 2;
          end else if (state_q == ST_SQA) begin
            ra_q <= (x_q >= trial) ? (res_q >> 1) + bit_q : res_q >> 1;
            x_q <= b_q[AccW-1] ? '0 : b_q;
            res_q <= '0; bit_q <= AccW'(64'd1 << 46);
            state_q <= ST_SQB;
          end else begin
            rb_q <= (x_q >= trial) ? (res_q >> 1) + bit_q : res_q >> 1;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          den_q <= AccW'(ra_q[23:0] * rb_q[23:0]);
          neg_q <= p_q[AccW-1];
          mag_q <= p_q[AccW-1] ? AccW'(-p_q) : AccW'(p_q);
          rem_q <= p_q[AccW-1] ? AccW'(-p_q) : AccW'(p_q);
          q_q <= '0; i_q <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_busy) begin
            if (rsh >= {1'b0, den_q}) begin
              rem_q <= AccW'(rsh - {1'b0, den_q}); q_q <= {q_q[22:0], 1'b1};
            end else begin
              rem_q <= rsh[AccW-1:0]; q_q <= {q_q[22:0], 1'b0};
            end
            i_q <= i_q + 1'b1;
          end else if (can_emit) begin
            odat_q.saturated <= sat_q;
            if (den_q == '0) odat_q.distance <= DistW'(One);
            else if (mag_q >= den_q)
              odat_q.distance <= neg_q ? DistW'(One << 1) : '0;
            else odat_q.distance <= neg_q ? DistW'(One + AccW'(q_q))
                                          : DistW'(One - AccW'(q_q));
            p_q <= '0; a_q <= '0; b_q <= '0; sat_q <= 1'b0;
            state_q <= ST_ACC;
          end
        end
        default: state_q <= ST_ACC;
      endcase
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odat_q;
endmodule
`default_nettype wire

>>> hw/rtl/vector_distance_engine.sv
// Takes one element pair per cycle into the multiply-accumulate path while
// nothing downstream stalls. L2 and inner product results pass the front's
// product register and the queue and are registered at the finisher output;
// cosine then spends 24 + 24 root steps, one multiply and up to 24 divide
// steps per vector there; the input stalls once the queue before it fills.
// ----------------------------------------------------------------------------
// vector_distance_engine
// vector distance (squared L2, cosine, negated inner product) top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "vector_distance_engine_macros.svh"
module vector_distance_engine #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  vde_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output vde_pkg::out_word_t  out_data_o
);
  import vde_pkg::*;

  logic [1:0] metric_q;
  logic f_vld, f_rdy, b_vld, b_rdy;
  term_t f_term, b_term;

  // metric register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) metric_q <= '0;
    else if (cfg_we_i) metric_q <= cfg_wdata_i;
  end

  vde_front #(.MaxDim(MAX_DIM)) u_front (
    .clk_i, .rst_ni, .metric_i(metric_q),
    .in_valid_i, .in_ready_o, .in_data_i,
    .term_valid_o(f_vld), .term_ready_i(f_rdy), .term_o(f_term)
  );

  vde_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_vld), .wr_ready_o(f_rdy), .wr_data_i(f_term),
    .rd_valid_o(b_vld), .rd_ready_i(b_rdy), .rd_data_o(b_term)
  );

  vde_back u_back (
    .clk_i, .rst_ni,
    .term_valid_i(b_vld), .term_ready_o(b_rdy), .term_i(b_term),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // a stalled result holds
  `VDE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // a queue that refuses terms always offers one to the back
  `VDE_ASSERT_IMPL(a_q_full, clk_i, rst_ni, !f_rdy, b_vld)
endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector distance engine testbench
// streams element pairs under random gaps and output stalls, switches the
// metric between phases and checks every distance word against a predictor
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import vde_pkg::*;

  localparam int     MaxDim     = 1024;
  localparam int     CycleLimit = 1500000;
  localparam longint AccMax     = (64'sd1 <<< 47) - 1;
  localparam longint AccMin     = -(64'sd1 <<< 47);
  localparam longint OutMax     = (64'sd1 <<< 43) - 1;
  localparam longint OutMin     = -(64'sd1 <<< 43);
  localparam longint FracOne    = 64'sd1 <<< 24;
  localparam logic [ElemW-1:0] EMax = 16'h7fff;
  localparam logic [ElemW-1:0] EMin = 16'h8000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = METRIC_L2;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  vector_distance_engine dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  metric_e   cur_metric = METRIC_L2;
  longint    prim_acc, norm_a_acc, norm_b_acc;
  bit        sat_flag;
  int        vec_len;
  out_word_t dist_q[$];
  int        errors, words_seen, words_sent, cycles;
  bit        hold_off;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic longint sat_add(input longint acc, input longint t);
    longint r;
    r = acc + t;
    if (r > AccMax) begin sat_flag = 1; return AccMax; end
    if (r < AccMin) begin sat_flag = 1; return AccMin; end
    return r;
  endfunction

  function automatic longint floor_root(input longint x);
    longint lo, hi, m;
    lo = 0; hi = 64'd16777216;
    while (lo < hi) begin
      m = (lo + hi + 1) / 2;
      if (m * m <= x) lo = m; else hi = m - 1;
    end
    return lo;
  endfunction

  function automatic longint cosine_dist();
    longint den, mag, q;
    den = floor_root(norm_a_acc > 0 ? norm_a_acc : 0) *
          floor_root(norm_b_acc > 0 ? norm_b_acc : 0);
    if (den == 0) return FracOne;
    mag = prim_acc < 0 ? -prim_acc : prim_acc;
    if (mag >= den) q = FracOne;
    else q = longint'((128'(mag) << 24) / 128'(den));
    return prim_acc < 0 ? FracOne + q : FracOne - q;
  endfunction

  // advance the predictor by one accepted word
  task automatic predict_distance(input in_word_t w);
    longint a, b, v;
    out_word_t r;
    a = w.elem_a; b = w.elem_b;
    if (cur_metric == METRIC_L2) prim_acc = sat_add(prim_acc, (a - b) * (a - b));
    else begin
      prim_acc = sat_add(prim_acc, a * b);
      if (cur_metric == METRIC_COS) begin
        norm_a_acc = sat_add(norm_a_acc, a * a);
        norm_b_acc = sat_add(norm_b_acc, b * b);
      end
    end
    if (!w.last && vec_len < MaxDim - 1) begin
      vec_len++;
      return;
    end
    case (cur_metric)
      METRIC_L2:  v = prim_acc;
      METRIC_COS: v = cosine_dist();
      default:    v = -prim_acc;
    endcase
    if (v > OutMax) begin v = OutMax; sat_flag = 1; end
    if (v < OutMin) begin v = OutMin; sat_flag = 1; end
    r.distance = v[DistW-1:0];
    r.saturated = sat_flag;
    dist_q.push_back(r);
    prim_acc = 0; norm_a_acc = 0; norm_b_acc = 0; sat_flag = 0; vec_len = 0;
  endtask

  // send one word with optional random gap before it
  task automatic send_word(input in_word_t w, input bit gaps);
    int g;
    g = 0;
    if (gaps) g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_distance(w);
    words_sent++;
  endtask

  task automatic set_metric(input metric_e m);
    in_valid_i <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_metric = m;
  endtask

  function automatic logic [ElemW-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return EMax;
      1: return EMin;
      2: return ElemW'($urandom_range(0, 8191)) - 16'd4096;
      default: return ElemW'($urandom);
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ready_i <= ~out_ready_i;
    else out_ready_i <= 1'b1;
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      if (dist_q.size() == 0) report("distance word with none expected");
      else begin
        if (out_data_o.distance !== dist_q[0].distance)
          report($sformatf("distance got %0d want %0d",
                 $signed(out_data_o.distance), $signed(dist_q[0].distance)));
        if (out_data_o.saturated !== dist_q[0].saturated)
          report($sformatf("saturated got %0b want %0b",
                 out_data_o.saturated, dist_q[0].saturated));
        void'(dist_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** vector_distance_engine: FAILED **");
      $finish;
    end
  end

  // directed table: a, b, last, metric, expected distance, check-exact flag
  typedef struct {
    logic [ElemW-1:0] a;
    logic [ElemW-1:0] b;
    bit               last;
    metric_e          m;
    longint           want;
    bit               typed;
  } row_t;

  row_t rows[] = '{
    '{16'h0000, 16'h0000, 1, METRIC_L2,  0,                 1},
    '{EMax,     EMin,     1, METRIC_L2,  64'sd65535 * 65535, 1},
    '{EMin,     EMin,     1, METRIC_L2,  0,                 1},
    '{16'h1000, 16'h0000, 0, METRIC_L2,  0,                 0},
    '{16'h0000, 16'h1000, 1, METRIC_L2,  2*FracOne,         1},
    '{EMin,     EMin,     1, METRIC_IP,  -(64'sd1 << 30),   1},
    '{EMax,     EMin,     1, METRIC_IP,  32767*32768,       1},
    '{16'h1000, 16'h1000, 0, METRIC_IP3, 0,                 0},
    '{16'h2000, 16'hf000, 1, METRIC_IP3, 0,                 0},
    '{16'h0000, 16'h0000, 1, METRIC_COS, FracOne,           1},
    '{16'h0000, 16'h1234, 1, METRIC_COS, FracOne,           1},
    '{16'h1000, 16'h1000, 1, METRIC_COS, 0,                 1},
    '{16'h1000, 16'hf000, 1, METRIC_COS, 2*FracOne,         1},
    '{EMax,     EMin,     1, METRIC_COS, 0,                 0},
    '{16'h0300, 16'h0700, 0, METRIC_COS, 0,                 0},
    '{16'hf900, 16'h0500, 1, METRIC_COS, 0,                 0}
  };

  in_word_t w;
  int       k, n, rnd_items;
  int       vec_cnt[4];
  metric_e  m_seq[6] = '{METRIC_COS, METRIC_L2, METRIC_IP, METRIC_IP3,
                         METRIC_COS, METRIC_L2};

  initial begin
    prim_acc = 0; norm_a_acc = 0; norm_b_acc = 0; sat_flag = 0; vec_len = 0;
    errors = 0; words_seen = 0; words_sent = 0; cycles = 0; hold_off = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows; exact rows are checked against the typed value too
    foreach (rows[i]) begin
      if (rows[i].m != cur_metric) set_metric(rows[i].m);
      w.elem_a = rows[i].a; w.elem_b = rows[i].b; w.last = rows[i].last;
      send_word(w, 0);
      if (rows[i].typed && dist_q.size() != 0 &&
          $signed(dist_q[$].distance) != rows[i].want)
        report($sformatf("row %0d predicted %0d typed %0d", i,
               $signed(dist_q[$].distance), rows[i].want));
    end

    // maximum length: long runs of extreme products under L2 and inner product
    set_metric(METRIC_L2);
    for (k = 0; k < MaxDim; k++) begin
      w.elem_a = EMax; w.elem_b = EMin; w.last = 1'b0;   // hits max length
      send_word(w, 0);
    end
    set_metric(METRIC_IP);
    for (k = 0; k < 50; k++) begin
      w.elem_a = EMin; w.elem_b = EMin; w.last = (k == 49);
      send_word(w, 0);
    end

    // metric change inside a vector
    w.elem_a = 16'h1000; w.elem_b = 16'h0800; w.last = 0;
    send_word(w, 0);
    in_valid_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    while (dist_q.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= METRIC_L2;
    @(posedge clk_i);
    cfg_we_i <= 1'b0; cur_metric = METRIC_L2;
    w.last = 1;
    send_word(w, 0);

    // random phases; mostly short vectors, a few long ones
    rnd_items = 0;
    for (int p = 0; p < 6; p++) begin
      set_metric(m_seq[p]);
      if (p == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      for (int v = 0; v < 10; v++) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) :
            $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          w.elem_a = rand_elem(); w.elem_b = rand_elem();
          if ($urandom_range(0, 4) == 0) w.elem_b = w.elem_a;
          w.last = (k == n - 1);
          send_word(w, 1);
          rnd_items++;
        end
        vec_cnt[m_seq[p]]++;
      end
    end

    in_valid_i <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("sent %0d words (%0d random), checked %0d distances", words_sent,
             rnd_items, words_seen);
    $display("random vectors per metric: l2 %0d cos %0d ip %0d ip3 %0d",
             vec_cnt[0], vec_cnt[1], vec_cnt[2], vec_cnt[3]);
    if (errors == 0 && dist_q.size() == 0) begin
      $display("** vector_distance_engine: PASSED **");
    end else begin
      $display("** vector_distance_engine: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/vde_pkg.sv
hw/rtl/vde_front.sv
hw/rtl/vde_queue.sv
hw/rtl/vde_back.sv
hw/rtl/vector_distance_engine.sv
bench/testbench.sv
